/* src/min_heap_priority_queue_core_defines.svh */
// Assertion macros for the min-heap priority queue core.
// Included by files that carry concurrent checks; expects clk and rst_n in scope.
`ifndef MIN_HEAP_PRIORITY_QUEUE_CORE_DEFINES_SVH
`define MIN_HEAP_PRIORITY_QUEUE_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define MHPQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define MHPQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/mhpq_pkg.sv */
// Shared types and constants for the min-heap priority queue core.
// No dependencies; used by the top level.
`default_nettype none

package mhpq_pkg;

  // command codes carried in tuser
  localparam int CMD_W = 2;
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_PEEK   = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,    // waiting for a command
    ST_ROOT,    // root read data present
    ST_LAST,    // last element read data present
    ST_UP,      // sift-up: issue parent read
    ST_UP_CMP,  // sift-up: compare with parent
    ST_DN_L,    // sift-down: issue left child read
    ST_DN_R,    // sift-down: latch left, issue right child read
    ST_DN_CMP   // sift-down: pick smallest, move hole
  } state_t;

endpackage

`default_nettype wire

/* src/mhpq_ram.sv */
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none

module mhpq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* src/min_heap_priority_queue_core.sv */
// Min-heap priority queue core: one command beat at a time; in_tready drops until it settles.
// Insert: the value enters at the new last slot and climbs, reading then comparing each parent.
// Peek/delete: the root value (empty flag on an empty heap) is staged, then output-registered.
// Delete sift-down: last element read, then per level ST_DN_L, ST_DN_R and ST_DN_CMP.
// A staged result also holds in_tready low until it moves to the output register.
// Reset (rst_n low, synchronous) empties the heap by clearing the count; no memory sweep.
`default_nettype none
`include "min_heap_priority_queue_core_defines.svh"

module min_heap_priority_queue_core #(
  parameter int CAPACITY    = 1024,
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,

  // command stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // [31:0] value
  input  wire logic [1:0]  in_tuser,   // [1:0] cmd

  // result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // [31:0] min_value
  output logic [0:0]       out_tuser   // [0] empty_res
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;  // heap address
  localparam int CW = $clog2(CAPACITY + 1);                    // element count
  localparam int IW = CW + 1;                                  // child index, may overrun

  // ---------------------------------------------------------------------------
  // Heap storage: one RAM, one read and one write per cycle.
  // A hole is carried through the heap: the moving value waits in v_r and is
  // written once, at its final slot; each level writes the displaced entry.
  // ---------------------------------------------------------------------------
  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [VALUE_WIDTH-1:0] ram_wdata;
  logic                   ram_re;
  logic [AW-1:0]          ram_raddr;
  logic [VALUE_WIDTH-1:0] ram_rdata;

  mhpq_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (CAPACITY)
  ) u_heap_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  mhpq_pkg::state_t       state_r, state_nxt;
  logic [CW-1:0]          count_r, count_nxt;
  logic [AW-1:0]          cur_r, cur_nxt;      // hole position
  logic [VALUE_WIDTH-1:0] v_r, v_nxt;          // value looking for a slot
  logic [VALUE_WIDTH-1:0] lv_r, lv_nxt;        // left child value
  logic                   rok_r, rok_nxt;      // right child exists
  logic                   pend_r, pend_nxt;    // result staged, not yet in output reg
  logic [31:0]            res_val_r, res_val_nxt;
  logic                   res_empty_r, res_empty_nxt;
  logic [1:0]             cmd_r;               // command of the beat in progress
  logic                   out_valid_r;
  logic [31:0]            out_val_r;
  logic                   out_empty_r;

  // ---------------------------------------------------------------------------
  // Handy values
  // ---------------------------------------------------------------------------
  logic                   in_acc;
  logic [1:0]             in_cmd;
  logic signed [63:0]     in_wide;
  logic [VALUE_WIDTH-1:0] in_val;
  logic signed [63:0]     rd_wide;
  logic [AW-1:0]          parent_idx;
  logic [IW-1:0]          l_idx;
  logic [IW-1:0]          r_idx;
  logic [IW-1:0]          count_ext;
  logic                   l_less;
  logic [VALUE_WIDTH-1:0] best_v;
  logic                   r_less;
  logic                   out_load;

  assign in_cmd     = in_tuser;
  assign in_acc     = in_tvalid && in_tready;
  // narrow or widen the 32-bit input to the stored width, keeping the sign
  assign in_wide    = 64'(signed'(in_tdata));
  assign in_val     = in_wide[VALUE_WIDTH-1:0];
  assign rd_wide    = 64'(signed'(ram_rdata));

  assign parent_idx = AW'((cur_r - AW'(1)) >> 1);
  assign l_idx      = IW'({cur_r, 1'b1});
  assign r_idx      = l_idx + IW'(1);
  assign count_ext  = IW'(count_r);

  // sift-down choice: smaller child, left one on ties
  assign l_less = $signed(lv_r) < $signed(v_r);
  assign best_v = l_less ? lv_r : v_r;
  assign r_less = rok_r && ($signed(ram_rdata) < $signed(best_v));

  // output register frees up when empty or drained this cycle
  assign out_load  = pend_r && (!out_valid_r || out_tready);
  assign in_tready = (state_r == mhpq_pkg::ST_IDLE) && !pend_r;

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    cur_nxt       = cur_r;
    v_nxt         = v_r;
    lv_nxt        = lv_r;
    rok_nxt       = rok_r;
    pend_nxt      = pend_r && !out_load;
    res_val_nxt   = res_val_r;
    res_empty_nxt = res_empty_r;
    ram_we        = 1'b0;
    ram_waddr     = cur_r;
    ram_wdata     = v_r;
    ram_re        = 1'b0;
    ram_raddr     = '0;

    case (state_r)
      mhpq_pkg::ST_IDLE: begin
        if (in_acc) begin
          case (in_cmd)
            mhpq_pkg::CMD_INSERT: begin
              // full heap drops the value
              if (count_r < CW'(CAPACITY)) begin
                cur_nxt   = AW'(count_r);
                v_nxt     = in_val;
                count_nxt = count_r + CW'(1);
                state_nxt = mhpq_pkg::ST_UP;
              end
            end
            mhpq_pkg::CMD_DELETE, mhpq_pkg::CMD_PEEK: begin
              if (count_r == '0) begin
                pend_nxt      = 1'b1;
                res_val_nxt   = '0;
                res_empty_nxt = 1'b1;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = '0;
                state_nxt = mhpq_pkg::ST_ROOT;
              end
            end
            default: begin
              // unused code: no effect
            end
          endcase
        end
      end

      mhpq_pkg::ST_ROOT: begin
        pend_nxt      = 1'b1;
        res_val_nxt   = rd_wide[31:0];
        res_empty_nxt = 1'b0;
        if (cmd_r == mhpq_pkg::CMD_DELETE) begin
          count_nxt = count_r - CW'(1);
          if (count_r == CW'(1)) begin
            state_nxt = mhpq_pkg::ST_IDLE;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = AW'(count_r - CW'(1));
            state_nxt = mhpq_pkg::ST_LAST;
          end
        end else begin
          state_nxt = mhpq_pkg::ST_IDLE;
        end
      end

      mhpq_pkg::ST_LAST: begin
        v_nxt     = ram_rdata;
        cur_nxt   = '0;
        state_nxt = mhpq_pkg::ST_DN_L;
      end

      mhpq_pkg::ST_UP: begin
        if (cur_r == '0) begin
          ram_we    = 1'b1;
          state_nxt = mhpq_pkg::ST_IDLE;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = parent_idx;
          state_nxt = mhpq_pkg::ST_UP_CMP;
        end
      end

      mhpq_pkg::ST_UP_CMP: begin
        ram_we = 1'b1;
        if ($signed(v_r) < $signed(ram_rdata)) begin
          // parent moves down into the hole
          ram_wdata = ram_rdata;
          cur_nxt   = parent_idx;
          state_nxt = mhpq_pkg::ST_UP;
        end else begin
          state_nxt = mhpq_pkg::ST_IDLE;
        end
      end

      mhpq_pkg::ST_DN_L: begin
        if (l_idx >= count_ext) begin
          // leaf reached
          ram_we    = 1'b1;
          state_nxt = mhpq_pkg::ST_IDLE;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = l_idx[AW-1:0];
          state_nxt = mhpq_pkg::ST_DN_R;
        end
      end

      mhpq_pkg::ST_DN_R: begin
        lv_nxt  = ram_rdata;
        rok_nxt = r_idx < count_ext;
        if (r_idx < count_ext) begin
          ram_re    = 1'b1;
          ram_raddr = r_idx[AW-1:0];
        end
        state_nxt = mhpq_pkg::ST_DN_CMP;
      end

      mhpq_pkg::ST_DN_CMP: begin
        ram_we = 1'b1;
        if (r_less) begin
          ram_wdata = ram_rdata;
          cur_nxt   = r_idx[AW-1:0];
          state_nxt = mhpq_pkg::ST_DN_L;
        end else if (l_less) begin
          ram_wdata = lv_r;
          cur_nxt   = l_idx[AW-1:0];
          state_nxt = mhpq_pkg::ST_DN_L;
        end else begin
          state_nxt = mhpq_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = mhpq_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mhpq_pkg::ST_IDLE;
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_r       <= cur_nxt;
    v_r         <= v_nxt;
    lv_r        <= lv_nxt;
    rok_r       <= rok_nxt;
    res_val_r   <= res_val_nxt;
    res_empty_r <= res_empty_nxt;
    if (in_acc) begin
      cmd_r <= in_cmd;
    end
    if (out_load) begin
      out_val_r   <= res_val_r;
      out_empty_r <= res_empty_r;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_val_r;
  assign out_tuser[0] = out_empty_r;

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  `MHPQ_ASSERT_NEXT(a_full_insert_drops, in_acc && (in_cmd == mhpq_pkg::CMD_INSERT) && (count_r == CW'(CAPACITY)), $stable(count_r), "insert into a full heap changed the count")
  `MHPQ_ASSERT_NOW(a_delete_shrinks, $past(in_acc, 2) && ($past(in_cmd, 2) == mhpq_pkg::CMD_DELETE) && ($past(count_r, 2) != '0), (count_r + CW'(1)) == $past(count_r, 2), "delete did not remove one element")
  `MHPQ_ASSERT_NEXT(a_peek_keeps, in_acc && (in_cmd == mhpq_pkg::CMD_PEEK), ($stable(count_r) && !ram_we), "peek altered the heap")

endmodule

`default_nettype wire

/* dv/min_heap_priority_queue_core_tb.sv */
// Self-checking bench for min_heap_priority_queue_core: command beats in, minimum beats out.
// Depends on mhpq_pkg (command codes) and the core RTL; a tracker class predicts results.
`timescale 1ns / 100ps

module min_heap_priority_queue_core_tb;

  localparam int          CAPACITY    = 1024;
  localparam int          CYCLE_LIMIT = 1000000;
  // margin after the last beat so the worst-case delete can finish
  localparam int          SETTLE_CYCLES = 80;
  // the fourth command code has no name in the package; the core must ignore it
  localparam logic [1:0]  CMD_UNUSED  = 2'd3;

  typedef struct {
    logic signed [31:0] min_value;
    logic               empty_res;
  } heap_result_t;

  // Shadow heap: mirrors the core's store and count, queues the minimums it owes.
  class min_heap_tracker;
    logic signed [31:0] store [CAPACITY];
    int unsigned        held;
    heap_result_t       pending [$];
    int unsigned        mismatch_count;

    function new();
      held           = 0;
      mismatch_count = 0;
    endfunction

    function void swap_entries(int unsigned a, int unsigned b);
      logic signed [31:0] t;
      t        = store[a];
      store[a] = store[b];
      store[b] = t;
    endfunction

    // append and climb while strictly below the parent; full heap drops the value
    function void push_value(logic signed [31:0] v);
      int unsigned cur;
      int unsigned up;
      if (held >= CAPACITY) return;
      cur        = held;
      store[cur] = v;
      held++;
      while (cur > 0) begin
        up = (cur - 1) / 2;
        if (!(store[cur] < store[up])) break;
        swap_entries(cur, up);
        cur = up;
      end
    endfunction

    // last element to the root, then sink it; smaller child wins, left on ties
    function void pop_root();
      int unsigned cur;
      int unsigned best;
      int unsigned l;
      int unsigned r;
      store[0] = store[held - 1];
      held--;
      cur = 0;
      while (1) begin
        best = cur;
        l    = 2 * cur + 1;
        r    = 2 * cur + 2;
        if (l < held && store[l] < store[best]) best = l;
        if (r < held && store[r] < store[best]) best = r;
        if (best == cur) break;
        swap_entries(cur, best);
        cur = best;
      end
    endfunction

    function void note_command(logic [1:0] cmd, logic [31:0] value);
      heap_result_t res;
      case (cmd)
        mhpq_pkg::CMD_INSERT: begin
          push_value($signed(value));
        end
        mhpq_pkg::CMD_DELETE, mhpq_pkg::CMD_PEEK: begin
          if (held == 0) begin
            res.min_value = '0;
            res.empty_res = 1'b1;
          end else begin
            res.min_value = store[0];
            res.empty_res = 1'b0;
            if (cmd == mhpq_pkg::CMD_DELETE) pop_root();
          end
          pending.push_back(res);
        end
        default: ;
      endcase
    endfunction

    function void check_result(logic [31:0] data, logic [0:0] user);
      heap_result_t want;
      if (pending.size() == 0) begin
        $error("unexpected beat: min_value %0d empty_res %0b", $signed(data), user[0]);
        mismatch_count++;
        return;
      end
      want = pending.pop_front();
      if (data !== want.min_value) begin
        $error("min_value: expected %0d, actual %0d", want.min_value, $signed(data));
        mismatch_count++;
      end
      if (user[0] !== want.empty_res) begin
        $error("empty_res: expected %0b, actual %0b", want.empty_res, user[0]);
        mismatch_count++;
      end
    endfunction
  endclass

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata   = '0;   // [31:0] value
  logic [1:0]  in_tuser   = '0;   // [1:0] cmd
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;         // [31:0] min_value
  logic [0:0]  out_tuser;         // [0] empty_res

  int          src_idle_pct = 0;
  int          snk_idle_pct = 0;
  int unsigned cycle_count  = 0;

  min_heap_tracker tracker = new();

  min_heap_priority_queue_core #(
    .CAPACITY    (CAPACITY),
    .VALUE_WIDTH (32)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // 20 ns period
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // watchdog: a hung handshake ends the run as a failure
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[min_heap_priority_queue_core] ERROR");
      $finish;
    end
  end

  // Result side: sample the handshake as it stood at the edge, then choose
  // the next tready. Back-pressure follows snk_idle_pct.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) tracker.check_result(out_tdata, out_tuser);
    out_tready <= ($urandom_range(99) >= snk_idle_pct);
  end

  // One command beat. Random gaps before it; tvalid stays high between
  // back-to-back beats so it is never dropped and raised in the same step.
  task automatic send_command(input logic [1:0] cmd, input logic [31:0] value);
    while ($urandom_range(99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= value;
    do @(posedge clk); while (!in_tready);
    tracker.note_command(cmd, value);
  endtask

  // Mostly full-range values; a share of small values to force equal keys,
  // and a few at the signed extremes.
  function automatic logic [31:0] pick_value();
    case ($urandom_range(7))
      0:       return $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      1, 2:    return $urandom_range(8) - 32'd4;
      default: return $urandom();
    endcase
  endfunction

  // Random mix, biased so the heap size wanders between empty and a few
  // dozen entries: deep enough for multi-level sifts, shallow enough to
  // empty out now and then.
  task automatic run_random(input int beats);
    int         roll;
    int         insert_pct;
    logic [1:0] cmd;
    repeat (beats) begin
      roll       = $urandom_range(99);
      insert_pct = (tracker.held < 4) ? 70 : ((tracker.held > 48) ? 30 : 50);
      if (roll < insert_pct)   cmd = mhpq_pkg::CMD_INSERT;
      else if (roll < 82)      cmd = mhpq_pkg::CMD_DELETE;
      else if (roll < 95)      cmd = mhpq_pkg::CMD_PEEK;
      else                     cmd = CMD_UNUSED;
      send_command(cmd, pick_value());
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // phase one: light source gaps, heavy sink stalls
    src_idle_pct = 16;
    snk_idle_pct = 46;

    // empty heap: both reading commands flag empty, unused code does nothing
    send_command(mhpq_pkg::CMD_PEEK,   32'h1234_5678);
    send_command(mhpq_pkg::CMD_DELETE, 32'hFFFF_FFFF);
    send_command(CMD_UNUSED,           32'h0000_0001);
    // extremes, alternating bit patterns and equal keys
    send_command(mhpq_pkg::CMD_INSERT, 32'h7FFF_FFFF);
    send_command(mhpq_pkg::CMD_INSERT, 32'h8000_0000);
    send_command(mhpq_pkg::CMD_INSERT, 32'h0000_0000);
    send_command(mhpq_pkg::CMD_INSERT, 32'hFFFF_FFFF);
    send_command(mhpq_pkg::CMD_INSERT, 32'h5555_5555);
    send_command(mhpq_pkg::CMD_INSERT, 32'hAAAA_AAAA);
    send_command(mhpq_pkg::CMD_INSERT, 32'd5);
    send_command(mhpq_pkg::CMD_INSERT, 32'd5);
    send_command(mhpq_pkg::CMD_PEEK,   32'h0000_0000);
    send_command(CMD_UNUSED,           32'h8000_0000);
    // drain in order, then hit empty again
    repeat (8) send_command(mhpq_pkg::CMD_DELETE, 32'h0000_0000);
    send_command(mhpq_pkg::CMD_DELETE, 32'h0000_0000);
    send_command(mhpq_pkg::CMD_PEEK,   32'h0000_0000);
    run_random(110);

    // phase two: roles swapped
    src_idle_pct = 46;
    snk_idle_pct = 16;
    run_random(115);

    // phase three: full rate both ways
    src_idle_pct = 0;
    snk_idle_pct = 0;
    run_random(115);

    // drain whatever is left, then one more delete on the empty heap
    while (tracker.held > 0) send_command(mhpq_pkg::CMD_DELETE, pick_value());
    send_command(mhpq_pkg::CMD_DELETE, 32'h0000_0000);
    in_tvalid <= 1'b0;

    while (tracker.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (tracker.mismatch_count == 0) begin
      $display("[min_heap_priority_queue_core] OK");
    end else begin
      $display("[min_heap_priority_queue_core] ERROR");
    end
    $finish;
  end

endmodule
